// File: rtl/core/djs_pkg.sv
// shared types and constants of the deadline job sequencer
package djs_pkg;

  localparam int MAX_JOBS_DEF   = 64;
  localparam int DEADLINE_W     = 16;
  localparam int PROFIT_W       = 16;
  localparam int JOB_COUNT_W    = 7;
  localparam int TOTAL_PROFIT_W = 22;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_CMP_INIT,
    ST_CMP_RD,
    ST_CMP_LOAD,
    ST_CMP_SCAN,
    ST_RESULT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic write_key;
    logic write_shift;
    logic read_prev;
    logic read_cur;
    logic bump_loaded;
    logic cmp_init;
    logic scan_init;
    logic dec_s;
    logic next_job;
    logic take;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic drop;
    logic last;
    logic j_zero;
    logic less;
    logic i_end;
    logic s_zero;
    logic slot_free;
    logic out_busy;
  } status_t;

endpackage

// File: rtl/core/djs_controller.sv
// control state machine of the deadline job sequencer
module djs_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  djs_pkg::status_t sts_i,
  output djs_pkg::cmd_t    cmd_o
);

  djs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= djs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != djs_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      djs_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = djs_pkg::ST_INS_CHK;
      end
      djs_pkg::ST_INS_CHK: begin
        priority if (sts_i.drop || sts_i.j_zero) begin
          state_d = sts_i.last ? djs_pkg::ST_CMP_INIT : djs_pkg::ST_IDLE;
        end else begin
          state_d = djs_pkg::ST_INS_CMP;
        end
      end
      djs_pkg::ST_INS_CMP: begin
        priority if (sts_i.less) begin
          state_d = djs_pkg::ST_INS_CHK;
        end else begin
          state_d = sts_i.last ? djs_pkg::ST_CMP_INIT : djs_pkg::ST_IDLE;
        end
      end
      djs_pkg::ST_CMP_INIT: state_d = djs_pkg::ST_CMP_RD;
      djs_pkg::ST_CMP_RD: begin
        state_d = sts_i.i_end ? djs_pkg::ST_RESULT : djs_pkg::ST_CMP_LOAD;
      end
      djs_pkg::ST_CMP_LOAD: state_d = djs_pkg::ST_CMP_SCAN;
      djs_pkg::ST_CMP_SCAN: begin
        if (sts_i.s_zero || sts_i.slot_free) state_d = djs_pkg::ST_CMP_RD;
      end
      djs_pkg::ST_RESULT: begin
        if (!sts_i.out_busy) state_d = djs_pkg::ST_IDLE;
      end
      default: state_d = djs_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      djs_pkg::ST_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      djs_pkg::ST_INS_CHK: begin
        priority if (sts_i.drop) begin
          cmd_o = '0;
        end else if (sts_i.j_zero) begin
          cmd_o.write_key   = 1'b1;
          cmd_o.bump_loaded = 1'b1;
        end else begin
          cmd_o.read_prev = 1'b1;
        end
      end
      djs_pkg::ST_INS_CMP: begin
        priority if (sts_i.less) begin
          cmd_o.write_shift = 1'b1;
        end else begin
          cmd_o.write_key   = 1'b1;
          cmd_o.bump_loaded = 1'b1;
        end
      end
      djs_pkg::ST_CMP_INIT: cmd_o.cmp_init = 1'b1;
      djs_pkg::ST_CMP_RD: begin
        cmd_o.read_cur = !sts_i.i_end;
      end
      djs_pkg::ST_CMP_LOAD: cmd_o.scan_init = 1'b1;
      djs_pkg::ST_CMP_SCAN: begin
        priority if (sts_i.s_zero) begin
          cmd_o.next_job = 1'b1;
        end else if (sts_i.slot_free) begin
          cmd_o.take = 1'b1;
        end else begin
          cmd_o.dec_s = 1'b1;
        end
      end
      djs_pkg::ST_RESULT: begin
        cmd_o.emit = !sts_i.out_busy;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: rtl/core/djs_datapath.sv
// job store, slot map, accumulators and result register
module djs_datapath #(
  parameter int MAX_JOBS = djs_pkg::MAX_JOBS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  djs_pkg::cmd_t                       cmd_i,
  output djs_pkg::status_t                    sts_o,
  input  logic [djs_pkg::DEADLINE_W-1:0]      deadline_i,
  input  logic [djs_pkg::PROFIT_W-1:0]        profit_i,
  input  logic                                last_job_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [djs_pkg::JOB_COUNT_W-1:0]     job_count_o,
  output logic [djs_pkg::TOTAL_PROFIT_W-1:0]  total_profit_o
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int PF_W  = djs_pkg::PROFIT_W;
  localparam int SUM_W = PF_W + CNT_W;

  // job store, kept sorted by descending profit
  logic [CNT_W-1:0] mem_dl [MAX_JOBS];
  logic [PF_W-1:0]  mem_pf [MAX_JOBS];
  logic [CNT_W-1:0] rd_dl_q;
  logic [PF_W-1:0]  rd_pf_q;

  logic [CNT_W-1:0] loaded_q, j_q, i_q, s_q;
  logic [CNT_W-1:0] key_dl_q;
  logic [PF_W-1:0]  key_pf_q;
  logic             key_last_q, drop_q;
  logic [MAX_JOBS-1:0] map_q, map_d;
  logic [CNT_W-1:0] count_q;
  logic [SUM_W-1:0] sum_q;
  logic             out_valid_q;
  logic [djs_pkg::JOB_COUNT_W-1:0]    job_count_q;
  logic [djs_pkg::TOTAL_PROFIT_W-1:0] total_profit_q;

  logic [CNT_W-1:0] jm1, sm1, dl_clamp;
  logic [IDX_W-1:0] waddr, raddr, sidx;
  logic             mem_we, mem_re;
  logic [CNT_W-1:0] wdl;
  logic [PF_W-1:0]  wpf;

  assign jm1   = j_q - CNT_W'(1);
  assign sm1   = s_q - CNT_W'(1);
  assign sidx  = sm1[IDX_W-1:0];
  assign waddr = j_q[IDX_W-1:0];
  assign raddr = cmd_i.read_prev ? jm1[IDX_W-1:0] : i_q[IDX_W-1:0];
  assign mem_we = cmd_i.write_key | cmd_i.write_shift;
  assign mem_re = cmd_i.read_prev | cmd_i.read_cur;
  assign wdl   = cmd_i.write_shift ? rd_dl_q : key_dl_q;
  assign wpf   = cmd_i.write_shift ? rd_pf_q : key_pf_q;

  assign dl_clamp = (deadline_i > djs_pkg::DEADLINE_W'(MAX_JOBS)) ?
                    CNT_W'(MAX_JOBS) : CNT_W'(deadline_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_dl[waddr] <= wdl;
      mem_pf[waddr] <= wpf;
    end
    if (mem_re) begin
      rd_dl_q <= mem_dl[raddr];
      rd_pf_q <= mem_pf[raddr];
    end
  end

  always_comb begin
    map_d = map_q;
    if (cmd_i.cmp_init || cmd_i.emit) begin
      map_d = '0;
    end else if (cmd_i.take) begin
      map_d[sidx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      j_q         <= '0;
      i_q         <= '0;
      s_q         <= '0;
      key_last_q  <= 1'b0;
      drop_q      <= 1'b0;
      map_q       <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      map_q <= map_d;
      if (cmd_i.emit) begin
        loaded_q <= '0;
      end else if (cmd_i.bump_loaded) begin
        loaded_q <= loaded_q + CNT_W'(1);
      end
      if (cmd_i.load) begin
        j_q        <= loaded_q;
        key_last_q <= last_job_i;
        drop_q     <= (loaded_q == CNT_W'(MAX_JOBS));
      end else if (cmd_i.write_shift) begin
        j_q <= jm1;
      end
      if (cmd_i.cmp_init) begin
        i_q <= '0;
      end else if (cmd_i.next_job || cmd_i.take) begin
        i_q <= i_q + CNT_W'(1);
      end
      if (cmd_i.scan_init) begin
        s_q <= rd_dl_q;
      end else if (cmd_i.dec_s) begin
        s_q <= sm1;
      end
      if (cmd_i.cmp_init) begin
        count_q <= '0;
        sum_q   <= '0;
      end else if (cmd_i.take) begin
        count_q <= count_q + CNT_W'(1);
        sum_q   <= sum_q + SUM_W'(rd_pf_q);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // key payload and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_dl_q <= dl_clamp;
      key_pf_q <= profit_i;
    end
    if (cmd_i.emit) begin
      job_count_q    <= djs_pkg::JOB_COUNT_W'(count_q);
      total_profit_q <= djs_pkg::TOTAL_PROFIT_W'(sum_q);
    end
  end

  assign sts_o.drop      = drop_q;
  assign sts_o.last      = key_last_q;
  assign sts_o.j_zero    = (j_q == '0);
  assign sts_o.less      = (rd_pf_q < key_pf_q);
  assign sts_o.i_end     = (i_q == loaded_q);
  assign sts_o.s_zero    = (s_q == '0);
  assign sts_o.slot_free = !map_q[sidx];
  assign sts_o.out_busy  = out_valid_q & out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign job_count_o    = job_count_q;
  assign total_profit_o = total_profit_q;

endmodule

// File: rtl/core/deadline_job_sequencer_top.sv
// top level of the deadline job sequencer
// Greedy job sequencing with deadlines. Each request carries one job (deadline,
// profit, last_job); last_job closes the set and starts scheduling. Jobs are
// inserted into a single-port job store kept in descending profit order; each
// stored job with lower profit moves back by one entry, a read in ST_INS_CHK
// followed by a write in ST_INS_CMP. After the last job the store is walked
// once; for each job its deadline is loaded and the slot map is scanned down
// from it, past taken slots, until a free slot is taken or none is left.
// One result (job_count, total_profit) follows each closed set and
// is held in an output register, so the next set can load while that result
// waits. Jobs beyond MAX_JOBS in one set are dropped; deadlines above MAX_JOBS
// act as MAX_JOBS. No clearing pass is needed after reset.
module deadline_job_sequencer_top #(
  parameter int MAX_JOBS = djs_pkg::MAX_JOBS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // job request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [djs_pkg::DEADLINE_W-1:0]      deadline_i,
  input  logic [djs_pkg::PROFIT_W-1:0]        profit_i,
  input  logic                                last_job_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [djs_pkg::JOB_COUNT_W-1:0]     job_count_o,
  output logic [djs_pkg::TOTAL_PROFIT_W-1:0]  total_profit_o
);

  djs_pkg::cmd_t    cmd;
  djs_pkg::status_t sts;

  // sequencing of load, insertion, scheduling and result hand-off
  djs_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // job store, slot map and accumulators
  djs_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .deadline_i     (deadline_i),
    .profit_i       (profit_i),
    .last_job_i     (last_job_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .job_count_o    (job_count_o),
    .total_profit_o (total_profit_o)
  );

endmodule

// File: rtl/core/djs_checker.sv
// port-level checks of the deadline job sequencer and their bind
module djs_checker #(
  parameter int MAX_JOBS = djs_pkg::MAX_JOBS_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [djs_pkg::DEADLINE_W-1:0]      deadline_i,
  input logic [djs_pkg::PROFIT_W-1:0]        profit_i,
  input logic                                last_job_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [djs_pkg::JOB_COUNT_W-1:0]     job_count_o,
  input logic [djs_pkg::TOTAL_PROFIT_W-1:0]  total_profit_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(job_count_o)
      && $stable(total_profit_o))
    else $error("result changed while stalled");

  // every accepted request keeps the block busy for the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken back to back");

  // no more jobs scheduled than slots
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(job_count_o) <= 32'(MAX_JOBS)))
    else $error("job count above slot count");

  // profit bounded by count times the largest profit
  a_profit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(total_profit_o) <= 32'(job_count_o) * 32'd65535))
    else $error("total profit exceeds bound");

  // nothing scheduled means nothing earned
  a_zero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (job_count_o == '0) |-> (total_profit_o == '0))
    else $error("profit without scheduled jobs");

endmodule

bind deadline_job_sequencer_top djs_checker #(.MAX_JOBS(MAX_JOBS)) u_djs_checker (.*);

// File: dv/djs_checker.sv
`timescale 1ns / 100ps
// checker for the deadline job sequencer: greedy schedule prediction and result compare
module djs_tb_checker #(
  parameter int MAX_JOBS = djs_pkg::MAX_JOBS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                job_valid_i,
  input  logic                                job_stall_i,
  input  logic [djs_pkg::DEADLINE_W-1:0]      deadline_i,
  input  logic [djs_pkg::PROFIT_W-1:0]        profit_i,
  input  logic                                last_job_i,
  input  logic                                res_valid_i,
  input  logic                                res_stall_i,
  input  logic [djs_pkg::JOB_COUNT_W-1:0]     job_count_i,
  input  logic [djs_pkg::TOTAL_PROFIT_W-1:0]  total_profit_i,
  output int                                  mismatch_count_o,
  output int                                  pending_o
);

  localparam int DL_W = $clog2(MAX_JOBS + 1);

  typedef struct packed {
    logic [djs_pkg::JOB_COUNT_W-1:0]    job_count;
    logic [djs_pkg::TOTAL_PROFIT_W-1:0] total_profit;
  } schedule_t;

  logic [DL_W-1:0]              held_deadline [MAX_JOBS];
  logic [djs_pkg::PROFIT_W-1:0] held_profit [MAX_JOBS];
  int                           held_count = 0;
  schedule_t                    pending_schedules [$];
  schedule_t                    oldest;

  // greedy sequencing over the held jobs of one closed set
  function automatic schedule_t schedule_jobs();
    logic [DL_W-1:0]              dl [MAX_JOBS];
    logic [djs_pkg::PROFIT_W-1:0] pf [MAX_JOBS];
    logic [MAX_JOBS:0]            taken;
    logic [DL_W-1:0]              kd;
    logic [djs_pkg::PROFIT_W-1:0] kp;
    logic [31:0]                  count;
    logic [63:0]                  sum;
    logic                         placed;
    int                           j;
    int                           s;
    schedule_t                    res;
    taken = '0;
    count = '0;
    sum   = '0;
    for (int i = 0; i < held_count; i++) begin
      dl[i] = held_deadline[i];
      pf[i] = held_profit[i];
    end
    // highest profit first
    for (int i = 1; i < held_count; i++) begin
      kd = dl[i];
      kp = pf[i];
      j  = i;
      while (j > 0 && pf[j-1] < kp) begin
        dl[j] = dl[j-1];
        pf[j] = pf[j-1];
        j--;
      end
      dl[j] = kd;
      pf[j] = kp;
    end
    // latest free slot at or before the deadline
    for (int i = 0; i < held_count; i++) begin
      placed = 1'b0;
      for (s = int'(dl[i]); s > 0 && !placed; s--) begin
        if (!taken[s]) begin
          taken[s] = 1'b1;
          placed   = 1'b1;
          count    = count + 1;
          sum      = sum + 64'(pf[i]);
        end
      end
    end
    res.job_count    = count[djs_pkg::JOB_COUNT_W-1:0];
    res.total_profit = sum[djs_pkg::TOTAL_PROFIT_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (pending_schedules.size() == 0) begin
          $error("result with no closed job set waiting: job_count %0d, total_profit %0d",
                 job_count_i, total_profit_i);
          mismatch_count_o++;
        end else begin
          oldest = pending_schedules.pop_front();
          if (job_count_i !== oldest.job_count) begin
            $error("job_count: expected %0d, actual %0d", oldest.job_count, job_count_i);
            mismatch_count_o++;
          end
          if (total_profit_i !== oldest.total_profit) begin
            $error("total_profit: expected %0d, actual %0d",
                   oldest.total_profit, total_profit_i);
            mismatch_count_o++;
          end
        end
      end
      if (job_valid_i && !job_stall_i) begin
        // jobs past a full set are dropped, their last mark still closes it
        if (held_count < MAX_JOBS) begin
          held_deadline[held_count] = (deadline_i > MAX_JOBS) ? DL_W'(MAX_JOBS)
                                                              : DL_W'(deadline_i);
          held_profit[held_count]   = profit_i;
          held_count++;
        end
        if (last_job_i) begin
          pending_schedules.insert(pending_schedules.size(), schedule_jobs());
          held_count = 0;
        end
      end
      pending_o = pending_schedules.size();
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// testbench top for the deadline job sequencer: stimulus, result stalls and verdict
module tb_top;

  localparam int ITEM_TARGET  = 950;
  localparam int HOLD_CYCLES  = 3000;     // long result hold-off to back up the block
  localparam int DRAIN_LIMIT  = 200000;   // cycles allowed for the last result
  localparam int TAIL_CYCLES  = 64;       // quiet cycles after the last result
  localparam int OVERFLOW_SET = 3;        // random set index forced past MAX_JOBS
  localparam int HOLD_SET     = 10;       // random set index that triggers the hold-off

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic [djs_pkg::DEADLINE_W-1:0]      deadline_i;
  logic [djs_pkg::PROFIT_W-1:0]        profit_i;
  logic                                last_job_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic [djs_pkg::JOB_COUNT_W-1:0]     job_count_o;
  logic [djs_pkg::TOTAL_PROFIT_W-1:0]  total_profit_o;

  int   mismatch_count;
  int   pending_sets;
  int   jobs_sent;
  bit   sender_quiet;   // no gaps between requests of the current set
  bit   hold_req;       // asks the result side for its long hold-off

  deadline_job_sequencer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .deadline_i     (deadline_i),
    .profit_i       (profit_i),
    .last_job_i     (last_job_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .job_count_o    (job_count_o),
    .total_profit_o (total_profit_o)
  );

  djs_tb_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (in_valid_i),
    .job_stall_i      (in_stall_o),
    .deadline_i       (deadline_i),
    .profit_i         (profit_i),
    .last_job_i       (last_job_i),
    .res_valid_i      (out_valid_o),
    .res_stall_i      (out_stall_i),
    .job_count_i      (job_count_o),
    .total_profit_i   (total_profit_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_sets)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)      return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 15);
    else             return $urandom_range(20, 80);
  endfunction

  // offer one job request from a falling edge, hold it until accepted,
  // then either keep valid up for the next request or open a gap
  task automatic send_job(input logic [djs_pkg::DEADLINE_W-1:0] dl,
                          input logic [djs_pkg::PROFIT_W-1:0] pf,
                          input logic last);
    int gap;
    deadline_i <= dl;
    profit_i   <= pf;
    last_job_i <= last;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    jobs_sent++;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // one well-formed set of n jobs with random content; the last one closes it
  task automatic send_random_set(input int n);
    logic [djs_pkg::DEADLINE_W-1:0] dl;
    logic [djs_pkg::PROFIT_W-1:0]   pf;
    int                             r;
    int                             dl_hi;
    dl_hi = (n < 64) ? n + 1 : 64;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 5)       dl = '0;                                            // never schedulable
      else if (r < 60) dl = djs_pkg::DEADLINE_W'($urandom_range(1, dl_hi)); // crowded slots
      else if (r < 75) dl = djs_pkg::DEADLINE_W'($urandom_range(1, 64));
      else if (r < 85) dl = djs_pkg::DEADLINE_W'($urandom_range(65, 65535)); // clamped
      else if (r < 90) dl = '1;
      else             dl = djs_pkg::DEADLINE_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 10)      pf = djs_pkg::PROFIT_W'($urandom_range(0, 3));  // lots of equal profits
      else if (r < 15) pf = '0;
      else if (r < 20) pf = '1;
      else             pf = djs_pkg::PROFIT_W'($urandom);
      send_job(dl, pf, k == n - 1);
    end
  endtask

  // result side: random stalls, quiet stretches, and one long hold-off
  initial begin : result_sink
    int  run;
    int  cyc;
    bit  hold_done;
    out_stall_i = 1'b0;
    run         = 0;
    cyc         = 0;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_req && !hold_done) begin
        // stall for a long stretch while jobs keep coming, so the input backs up
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (run > 0) begin
        run--;
      end else if ((cyc / 400) % 5 == 3) begin
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) < 30) begin
        out_stall_i <= 1'b1;
        run = pick_gap();
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // job side: reset, directed sets, random sets, drain and verdict
  initial begin : job_source
    int set_idx;
    int n;
    int r;
    int waited;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    deadline_i   = '0;
    profit_i     = '0;
    last_job_i   = 1'b0;
    jobs_sent    = 0;
    sender_quiet = 1'b0;
    hold_req     = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // single-job sets at the field extremes
    send_job(16'd0,     16'hFFFF, 1'b1);  // zero deadline never fits
    send_job(16'd1,     16'd0,    1'b1);  // scheduled with zero profit
    send_job(16'hFFFF,  16'hFFFF, 1'b1);  // largest deadline and profit
    // textbook set where greedy skips the conflicting jobs
    send_job(16'd2,     16'd100,  1'b0);
    send_job(16'd1,     16'd19,   1'b0);
    send_job(16'd2,     16'd27,   1'b0);
    send_job(16'd1,     16'd25,   1'b0);
    send_job(16'd3,     16'd15,   1'b1);
    // equal profits competing for the same slots
    send_job(16'd1,     16'd7,    1'b0);
    send_job(16'd1,     16'd7,    1'b0);
    send_job(16'd2,     16'd7,    1'b1);
    // deadlines at and above the slot count, the ones above it clamped
    send_job(16'd65,    16'd1,    1'b0);
    send_job(16'd64,    16'd2,    1'b0);
    send_job(16'hFFFF,  16'd3,    1'b1);
    // nothing schedulable in the whole set
    send_job(16'd0,     16'd5,    1'b0);
    send_job(16'd0,     16'd6,    1'b1);
    // top slots with full profits
    send_job(16'd64,    16'hFFFF, 1'b0);
    send_job(16'd63,    16'hFFFF, 1'b1);

    // random sets: mostly small, a few large, one forced and some random ones past the set size
    set_idx = 0;
    while (jobs_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (set_idx == OVERFLOW_SET) n = $urandom_range(65, 72);
      else if (set_idx == HOLD_SET || set_idx == HOLD_SET + 1)
                                   n = $urandom_range(1, 10);  // fill up inside the hold-off
      else if (r < 80)             n = $urandom_range(1, 10);
      else if (r < 92)             n = $urandom_range(11, 30);
      else if (r < 98)             n = $urandom_range(31, 64);
      else                         n = $urandom_range(65, 72);
      if (set_idx == HOLD_SET) hold_req = 1'b1;
      sender_quiet = (set_idx % 5 == 2);
      send_random_set(n);
      set_idx++;
    end
    in_valid_i <= 1'b0;

    // wait for every closed set to report, then a quiet tail
    waited = 0;
    while (pending_sets != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_sets != 0) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk_i);
      if (mismatch_count == 0 && pending_sets == 0) begin
        $display("*** PASSED ***");
      end else begin
        $display("*** FAILED ***");
      end
      $finish;
    end
  end

  // hard stop well past the slowest correct run
  initial begin : run_limit
    #15_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
